FILE: hdl/tarhp_pkg.sv
// shared constants, codes and types for the ustar header field parser
`default_nettype none

package tarhp_pkg;

    // header geometry
    localparam int HEADER_BYTES = 512;
    localparam int SECTOR_BYTES = 512;
    localparam int POS_W        = $clog2(HEADER_BYTES);

    localparam logic [POS_W-1:0] SIZE_FIRST  = POS_W'(124);
    localparam logic [POS_W-1:0] SIZE_LAST   = POS_W'(124 + 12 - 1);
    localparam logic [POS_W-1:0] TYPE_POS    = POS_W'(156);
    localparam logic [POS_W-1:0] MAGIC_FIRST = POS_W'(257);
    localparam logic [POS_W-1:0] MAGIC_LAST  = POS_W'(257 + 6 - 1);
    localparam logic [POS_W-1:0] LAST_POS    = POS_W'(HEADER_BYTES - 1);

    // skip = round_up(size + header, sector); header is a whole number of sectors
    localparam logic [63:0] SECTOR_MASK = 64'(SECTOR_BYTES - 1);
    localparam logic [63:0] SKIP_BIAS   = 64'(HEADER_BYTES + SECTOR_BYTES - 1);

    // ascii characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] B256_FLAG = 8'h80;
    localparam logic [7:0] B256_BITS = 8'h7F;

    // size parser phases
    localparam logic [2:0] PH_FIRST   = 3'd0;
    localparam logic [2:0] PH_BASE256 = 3'd1;
    localparam logic [2:0] PH_SPACES  = 3'd2;
    localparam logic [2:0] PH_DIGITS  = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;
    localparam logic [2:0] PH_BAD     = 3'd5;

    // finished header fields handed from the byte tracker to the result stage
    typedef struct packed {
        logic [63:0] size;
        logic        malformed;
        logic        magic_ok;
        logic [7:0]  type_code;
    } hdr_snap_t;

    // expected magic text "ustar "
    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h75;
            3'd1:    ch = 8'h73;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h61;
            3'd4:    ch = 8'h72;
            3'd5:    ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/tarhp_fields.sv
// per-byte header tracker: position, size parser, magic check, type capture
`default_nettype none

module tarhp_fields
    import tarhp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       take,
    input  wire logic [7:0] header_byte,
    output logic            snap_fire,
    output hdr_snap_t       snap
);

    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [2:0]       phase_reg, phase_next;
    logic [63:0]      acc_reg,   acc_next;
    logic             magic_reg, magic_next;
    logic [7:0]       type_reg,  type_next;

    logic             in_size;
    logic             in_magic;
    logic             last;
    logic [2:0]       magic_idx;
    logic             is_end;
    logic             is_octal;

    assign in_size   = (pos_reg >= SIZE_FIRST) && (pos_reg <= SIZE_LAST);
    assign in_magic  = (pos_reg >= MAGIC_FIRST) && (pos_reg <= MAGIC_LAST);
    assign last      = (pos_reg == LAST_POS);
    assign magic_idx = 3'(pos_reg - MAGIC_FIRST);
    assign is_end    = (header_byte == CH_NUL) || (header_byte == CH_SPACE);
    assign is_octal  = (header_byte >= CH_ZERO) && (header_byte <= CH_SEVEN);

    // next state for one accepted beat
    always_comb
    begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        acc_next   = acc_reg;
        magic_next = magic_reg;
        type_next  = type_reg;

        if (take)
        begin
            pos_next = pos_reg + POS_W'(1);

            // size field
            if (in_size)
            begin
                if (pos_reg == SIZE_FIRST && (header_byte & B256_FLAG) != 8'h00)
                begin
                    acc_next   = {56'd0, header_byte & B256_BITS};
                    phase_next = PH_BASE256;
                end
                else if (pos_reg == SIZE_FIRST && header_byte == CH_SPACE)
                begin
                    phase_next = PH_SPACES;
                end
                else if (pos_reg == SIZE_FIRST || phase_reg == PH_DIGITS ||
                         (phase_reg == PH_SPACES && header_byte != CH_SPACE))
                begin
                    // one octal character
                    priority if (is_end)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (!is_octal)
                    begin
                        acc_next   = 64'd0;
                        phase_next = PH_BAD;
                    end
                    else
                    begin
                        acc_next   = {acc_reg[60:0], header_byte[2:0]};
                        phase_next = PH_DIGITS;
                    end
                end
                else if (phase_reg == PH_BASE256)
                begin
                    acc_next = {acc_reg[55:0], header_byte};
                end
            end

            // type byte
            if (pos_reg == TYPE_POS)
            begin
                type_next = header_byte;
            end

            // magic compare
            if (in_magic && header_byte != magic_char(magic_idx))
            begin
                magic_next = 1'b0;
            end

            // end of header: back to the start state
            if (last)
            begin
                pos_next   = '0;
                phase_next = PH_FIRST;
                acc_next   = 64'd0;
                magic_next = 1'b1;
                type_next  = 8'd0;
            end
        end
    end

    // tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= PH_FIRST;
            acc_reg   <= 64'd0;
            magic_reg <= 1'b1;
            type_reg  <= 8'd0;
        end
        else
        begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            magic_reg <= magic_next;
            type_reg  <= type_next;
        end
    end

    // the last byte touches no field, so the held state is already final
    assign snap_fire      = take && last;
    assign snap.size      = acc_reg;
    assign snap.malformed = (phase_reg == PH_BAD);
    assign snap.magic_ok  = magic_reg;
    assign snap.type_code = type_reg - CH_ZERO;

endmodule

`default_nettype wire

FILE: hdl/tarhp_result.sv
// result stage: snapshot register, skip distance add and output register
`default_nettype none

module tarhp_result
    import tarhp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   snap_fire,
    input  wire hdr_snap_t snap,
    output logic        busy,
    output logic        out_valid,
    input  wire logic   out_stall,
    output logic [63:0] entry_size,
    output logic        size_malformed,
    output logic        magic_ok,
    output logic [7:0]  type_code,
    output logic [63:0] skip_bytes
);

    logic        snap_valid_reg, snap_valid_next;
    hdr_snap_t   snap_reg;
    logic        out_valid_reg,  out_valid_next;
    hdr_snap_t   out_reg;
    logic [63:0] skip_reg;
    logic        advance;

    // snapshot moves on when the output register is free or being drained
    assign advance = snap_valid_reg && (!out_valid_reg || !out_stall);
    assign busy    = snap_valid_reg && out_valid_reg && out_stall;

    always_comb
    begin
        snap_valid_next = snap_valid_reg;
        if (snap_fire)
            snap_valid_next = 1'b1;
        else if (advance)
            snap_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            snap_valid_reg <= snap_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (snap_fire)
            snap_reg <= snap;
        if (advance)
        begin
            out_reg  <= snap_reg;
            skip_reg <= (snap_reg.size + SKIP_BIAS) & ~SECTOR_MASK;
        end
    end

    assign out_valid      = out_valid_reg;
    assign entry_size     = out_reg.size;
    assign size_malformed = out_reg.malformed;
    assign magic_ok       = out_reg.magic_ok;
    assign type_code      = out_reg.type_code;
    assign skip_bytes     = skip_reg;

endmodule

`default_nettype wire

FILE: hdl/tar_header_field_parser_core.sv
// ustar header field parser: top level
//
// Input channel: one header byte per beat on header_byte, in_valid / in_stall.
// A header is 512 beats; after the 512th beat the block issues one result
// beat on the output channel (out_valid / out_stall) carrying entry_size,
// size_malformed, magic_ok, type_code and skip_bytes.
// Throughput: one header byte per cycle while in_stall is low, back to back
// across headers. The snapshot register loads on the edge that takes the last
// byte; the output register, with the skip add, loads from it once it is free
// or being drained, and out_valid rises as it loads.
// When the receiver stalls, the result holds in the output register and the
// next finished header waits in the snapshot register; in_stall rises only
// when both are full, so byte intake continues for almost a whole header.
// Reset (rst_n low, asynchronous) returns the byte counter to the first
// header byte, clears the size parser and magic check, and drops out_valid.
`default_nettype none

module tar_header_field_parser_core
    import tarhp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] header_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [63:0]     entry_size,
    output logic            size_malformed,
    output logic            magic_ok,
    output logic [7:0]      type_code,
    output logic [63:0]     skip_bytes
);

    logic      take;
    logic      busy;
    logic      snap_fire;
    hdr_snap_t snap;

    assign in_stall = busy;
    assign take     = in_valid && !busy;

    // byte tracker
    tarhp_fields u_fields (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .header_byte (header_byte),
        .snap_fire   (snap_fire),
        .snap        (snap)
    );

    // result stage
    tarhp_result u_result (
        .clk            (clk),
        .rst_n          (rst_n),
        .snap_fire      (snap_fire),
        .snap           (snap),
        .busy           (busy),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .entry_size     (entry_size),
        .size_malformed (size_malformed),
        .magic_ok       (magic_ok),
        .type_code      (type_code),
        .skip_bytes     (skip_bytes)
    );

    // a malformed size always reads as zero
    a_malformed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && size_malformed |-> entry_size == 64'd0)
        else $error("malformed size not zero");

    // skip distance is sector aligned
    a_skip_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (skip_bytes & SECTOR_MASK) == 64'd0)
        else $error("skip distance not sector aligned");

    // a finished header reaches the output when no held result blocks it
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        snap_fire && !(out_valid && out_stall) |-> ##2 out_valid)
        else $error("result did not appear");

    // the input only stalls while a result is held at the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

endmodule

`default_nettype wire
